// ===== rtl/core/legendre_polynomial_eval_macros.svh =====
// Assertion macros shared by the Legendre evaluator RTL.
`ifndef LEGENDRE_POLYNOMIAL_EVAL_MACROS_SVH
`define LEGENDRE_POLYNOMIAL_EVAL_MACROS_SVH
`ifndef SYNTHESIS
`define LPE_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define LPE_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define LPE_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define LPE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/lpe_pkg.sv =====
// Types, codes and saturating helpers for the Legendre evaluator.
package lpe_pkg;
  localparam int MAX_DEGREE_DEF = 64;
  localparam int FRAC_BITS_DEF  = 30;

  localparam logic [1:0] OP_VALUE  = 2'd0;
  localparam logic [1:0] OP_DERIV1 = 2'd1;
  localparam logic [1:0] OP_DERIV2 = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic signed [63:0] q_t;

  typedef struct packed {
    logic sat;
    q_t   val;
  } satq_t;

  function automatic logic [63:0] mag64(input q_t a);
    mag64 = a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic satq_t sat_sub(input q_t a, input q_t b);
    satq_t r;
    r.val = a - b;
    r.sat = 1'b0;
    if ((a[63] != b[63]) && (r.val[63] != a[63])) begin
      r.sat = 1'b1;
      r.val = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    sat_sub = r;
  endfunction

  // Sign plus 128-bit magnitude to a saturated 64-bit value.
  function automatic satq_t pack128(input logic neg, input logic [127:0] v);
    satq_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (v > {64'd0, 1'b1, 63'd0}) begin
        r.sat = 1'b1;
        r.val = {1'b1, 63'd0};
      end else begin
        r.val = 64'd0 - v[63:0];
      end
    end else begin
      if (v > {65'd0, {63{1'b1}}}) begin
        r.sat = 1'b1;
        r.val = {1'b0, {63{1'b1}}};
      end else begin
        r.val = v[63:0];
      end
    end
    pack128 = r;
  endfunction
endpackage

// ===== rtl/core/lpe_in_if.sv =====
// Input channel: evaluation point, degree and operation.
interface lpe_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] x_value;
  logic [6:0]        degree;
  logic [1:0]        operation;
  modport source (output valid, x_value, degree, operation, input ready);
  modport sink   (input valid, x_value, degree, operation, output ready);
endinterface

// ===== rtl/core/lpe_out_if.sv =====
// Result channel: saturated fixed-point result and status.
interface lpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [1:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== rtl/core/legendre_polynomial_eval.sv =====
// Legendre polynomial evaluator top level: sequencer over a shared multiplier and divider.
//
// in_ch takes x (Q.FRAC_BITS), degree n and operation (value, first or second
// derivative); out_ch returns one result word and a status per input word.
// in_ch.ready is high only while the block is idle; one word is in work at a time.
// The data path is one 64x64 multiplier built from 32x32 partial products
// and one restoring divider retiring one quotient bit per cycle, used for
// the division by k+1 and for the derivative quotient.
// Each Bonnet step is dominated by the divider. First derivative adds a
// derivative step after the recurrence, and second derivative runs the
// first-derivative sequence twice plus a final difference step.
// The result word sits in an output register until out_ch.ready takes it; the
// block stays busy and holds it while the receiver stalls.
// Synchronous active-low reset returns the sequencer to idle and drops
// out_ch.valid; no state survives between words.
// Degrees above MAX_DEGREE are clamped; operation code three means value mode.
`include "legendre_polynomial_eval_macros.svh"
module legendre_polynomial_eval
  import lpe_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lpe_in_if.sink     in_ch,
  lpe_out_if.source  out_ch
);
  localparam int NW = $clog2(MAX_DEGREE + 1);
  localparam logic [63:0] ONE_U = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_STEP = ((64'd1 << FRAC_BITS) * 64'd5 + 64'd500) / 64'd1000;
  localparam q_t ONE_Q = q_t'(ONE_U);
  localparam q_t HALF_Q = q_t'(HALF_STEP);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_LOOP, S_L1, S_L2, S_L3, S_L4, S_LDONE,
    S_D1, S_D2, S_D3, S_D4, S_DEND, S_FIN,
    S_MUL, S_MPACK, S_DIV, S_DPACK, S_DONE, S_OUT
  } state_t;

  state_t state_r, ret_r;
  q_t x_r, xcur_r, p0_r, p1_r, t_r, dp_r, res_r, mres_r, dres_r;
  logic [NW-1:0] n_r, k_r;
  logic [1:0] op_r;
  logic pass_r, sat_r, divz_r;

  // multiplier
  logic [63:0]  ma_r, mb_r, pp_r;
  logic [127:0] acc_r;
  logic [1:0]   psh_r;
  logic [2:0]   mcnt_r;
  logic         mneg_r, mq_r;
  // divider
  logic [127:0] dd_r, q_r;
  logic [63:0]  md_r, rem_r;
  logic [6:0]   dcnt_r;
  logic         dneg_r, dq_r;

  logic signed [63:0] out_res_r;
  logic [1:0] out_st_r;
  logic out_valid_r;

  logic [31:0]  pa, pb;
  logic [127:0] rnd, mv, qr;
  logic [64:0]  rsh;
  logic         ge;
  satq_t mpack, dpack, s_l3, s_d1, s_d3, s_fin;
  logic [NW:0]  k1, k2p1;

  always_comb begin
    pa = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    pb = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    rnd = acc_r + (128'd1 << (FRAC_BITS - 1));
    mv = mq_r ? (rnd >> FRAC_BITS) : acc_r;
    mpack = pack128(mneg_r, mv);
    rsh = {rem_r, dd_r[127]};
    ge = rsh >= {1'b0, md_r};
    qr = q_r + 128'(({rem_r, 1'b0} >= {1'b0, md_r}));
    dpack = pack128(dneg_r, qr);
    s_l3 = sat_sub(t_r, mres_r);
    s_d1 = sat_sub(mres_r, p0_r);
    s_d3 = sat_sub(mres_r, ONE_Q);
    s_fin = sat_sub(dp_r, dres_r);
    k1 = {1'b0, k_r} + 1'b1;
    k2p1 = {k_r, 1'b1};
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.status = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      out_valid_r <= 1'b0;
      mcnt_r <= '0;
      dcnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_r <= q_t'(in_ch.x_value);
            n_r <= (int'(in_ch.degree) > MAX_DEGREE) ? NW'(MAX_DEGREE) : NW'(in_ch.degree);
            op_r <= in_ch.operation;
            xcur_r <= (in_ch.operation == OP_DERIV2) ? q_t'(in_ch.x_value) + HALF_Q
                                                     : q_t'(in_ch.x_value);
            pass_r <= 1'b0;
            sat_r <= 1'b0;
            divz_r <= 1'b0;
            state_r <= S_START;
          end
        end
        S_START: begin
          p0_r <= ONE_Q;
          p1_r <= (n_r == '0) ? ONE_Q : xcur_r;
          k_r <= NW'(1);
          state_r <= S_LOOP;
        end
        S_LOOP: begin
          if (k_r < n_r) begin
            ma_r <= mag64(xcur_r); mb_r <= mag64(p1_r);
            mneg_r <= xcur_r[63] ^ p1_r[63]; mq_r <= 1'b1;
            acc_r <= '0; mcnt_r <= '0; ret_r <= S_L1; state_r <= S_MUL;
          end else begin
            state_r <= S_LDONE;
          end
        end
        S_L1: begin
          ma_r <= mag64(mres_r); mb_r <= 64'(k2p1);
          mneg_r <= mres_r[63]; mq_r <= 1'b0;
          acc_r <= '0; mcnt_r <= '0; ret_r <= S_L2; state_r <= S_MUL;
        end
        S_L2: begin
          t_r <= mres_r;
          ma_r <= mag64(p0_r); mb_r <= 64'(k_r);
          mneg_r <= p0_r[63]; mq_r <= 1'b0;
          acc_r <= '0; mcnt_r <= '0; ret_r <= S_L3; state_r <= S_MUL;
        end
        S_L3: begin
          sat_r <= sat_r | s_l3.sat;
          dd_r <= {mag64(s_l3.val) + 64'(k1 >> 1), 64'd0};
          md_r <= 64'(k1);
          dneg_r <= s_l3.val[63]; dq_r <= 1'b0;
          rem_r <= '0; q_r <= '0; dcnt_r <= 7'd63;
          ret_r <= S_L4; state_r <= S_DIV;
        end
        S_L4: begin
          p0_r <= p1_r;
          p1_r <= dres_r;
          k_r <= k_r + 1'b1;
          state_r <= S_LOOP;
        end
        S_LDONE: begin
          if (op_r == OP_DERIV1 || op_r == OP_DERIV2) begin
            ma_r <= mag64(xcur_r); mb_r <= mag64(p1_r);
            mneg_r <= xcur_r[63] ^ p1_r[63]; mq_r <= 1'b1;
            acc_r <= '0; mcnt_r <= '0; ret_r <= S_D1; state_r <= S_MUL;
          end else begin
            res_r <= p1_r;
            state_r <= S_DONE;
          end
        end
        S_D1: begin
          sat_r <= sat_r | s_d1.sat;
          ma_r <= mag64(s_d1.val); mb_r <= 64'(n_r);
          mneg_r <= s_d1.val[63]; mq_r <= 1'b0;
          acc_r <= '0; mcnt_r <= '0; ret_r <= S_D2; state_r <= S_MUL;
        end
        S_D2: begin
          t_r <= mres_r;
          ma_r <= mag64(xcur_r); mb_r <= mag64(xcur_r);
          mneg_r <= 1'b0; mq_r <= 1'b1;
          acc_r <= '0; mcnt_r <= '0; ret_r <= S_D3; state_r <= S_MUL;
        end
        S_D3: begin
          sat_r <= sat_r | s_d3.sat;
          if (s_d3.val == '0) begin
            divz_r <= 1'b1;
            dres_r <= '0;
            state_r <= S_DEND;
          end else begin
            dd_r <= 128'(mag64(t_r)) << FRAC_BITS;
            md_r <= mag64(s_d3.val);
            dneg_r <= t_r[63] ^ s_d3.val[63]; dq_r <= 1'b1;
            rem_r <= '0; q_r <= '0; dcnt_r <= 7'd127;
            ret_r <= S_D4; state_r <= S_DIV;
          end
        end
        S_D4: state_r <= S_DEND;
        S_DEND: begin
          if (op_r == OP_DERIV2 && !pass_r) begin
            dp_r <= dres_r;
            pass_r <= 1'b1;
            xcur_r <= x_r - HALF_Q;
            state_r <= S_START;
          end else if (op_r == OP_DERIV2) begin
            sat_r <= sat_r | s_fin.sat;
            ma_r <= mag64(s_fin.val); mb_r <= 64'd100;
            mneg_r <= s_fin.val[63]; mq_r <= 1'b0;
            acc_r <= '0; mcnt_r <= '0; ret_r <= S_FIN; state_r <= S_MUL;
          end else begin
            res_r <= dres_r;
            state_r <= S_DONE;
          end
        end
        S_FIN: begin
          res_r <= mres_r;
          state_r <= S_DONE;
        end
        S_MUL: begin
          // product of one half pair, then accumulate it next cycle
          pp_r <= pa * pb;
          psh_r <= {mcnt_r[1] & mcnt_r[0], mcnt_r[1] ^ mcnt_r[0]};
          if (mcnt_r != 3'd0) begin
            acc_r <= acc_r + (128'(pp_r) << {psh_r, 5'd0});
          end
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r == 3'd4) begin
            state_r <= S_MPACK;
          end
        end
        S_MPACK: begin
          mres_r <= mpack.val;
          sat_r <= sat_r | mpack.sat;
          state_r <= ret_r;
        end
        S_DIV: begin
          rem_r <= ge ? 64'(rsh - {1'b0, md_r}) : rsh[63:0];
          q_r <= {q_r[126:0], ge};
          dd_r <= dd_r << 1;
          dcnt_r <= dcnt_r - 7'd1;
          if (dcnt_r == 7'd0) begin
            state_r <= S_DPACK;
          end
        end
        S_DPACK: begin
          if (dq_r) begin
            dres_r <= dpack.val;
            sat_r <= sat_r | dpack.sat;
          end else begin
            dres_r <= dneg_r ? q_t'(64'd0 - q_r[63:0]) : q_t'(q_r[63:0]);
          end
          state_r <= ret_r;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_res_r <= divz_r ? q_t'(0) : res_r;
          out_st_r <= divz_r ? ST_DIVZ : (sat_r ? ST_SAT : ST_OK);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LPE_ASSERT_IMPLIES(a_ready_not_busy, clk, rst_n, in_ch.ready, !out_ch.valid)
  `LPE_ASSERT_IMPLIES(a_divz_zero, clk, rst_n, out_ch.valid && out_ch.status == ST_DIVZ, out_ch.result_value == 0)
  `LPE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
endmodule
